// ===== rtl/core/itra_pkg.sv =====
`default_nettype none
package itra_pkg;

  // default data width of the converted integer
  localparam int DEF_WIDTH = 32;

  // radix register and digit widths
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;

  // radix limits and the one radix that carries a sign
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // character codes
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_A     = 8'h61;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] LETTER_OFS = 8'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 6'd9;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SIGN,
    S_EMIT
  } seq_state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

  // digit value to lower-case ASCII
  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d > DIGIT_MAX) begin
      return d8 - LETTER_OFS + CHR_A;
    end
    return d8 + CHR_ZERO;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/itra_div.sv =====
`default_nettype none
module itra_div #(
  parameter int WIDTH = itra_pkg::DEF_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         go,
  input  wire logic [WIDTH-1:0]             dividend,
  input  wire logic [itra_pkg::RADIX_W-1:0] divisor,
  output      logic [WIDTH-1:0]             quo,
  output      itra_pkg::div_res_t           res
);
  import itra_pkg::*;

  localparam int CW = $clog2(WIDTH);

  logic                 running;
  logic                 done;
  logic [CW-1:0]        cnt;
  logic [RADIX_W-1:0]   dsr;
  logic [DIGIT_W-1:0]   rem;
  logic [DIGIT_W:0]     sh;
  logic                 ge;
  logic [DIGIT_W-1:0]   rem_step;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    sh       = {rem, quo[WIDTH-1]};
    ge       = (sh >= {1'b0, dsr});
    rem_step = ge ? DIGIT_W'(sh - {1'b0, dsr}) : sh[DIGIT_W-1:0];
  end

  // control: one quotient bit a cycle, done pulse after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
      end else if (running && (cnt == '0)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      cnt <= CW'(WIDTH - 1);
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (running) begin
      cnt <= cnt - 1'b1;
      quo <= {quo[WIDTH-2:0], ge};
      rem <= rem_step;
    end
  end

  assign res.done = done;
  assign res.rem  = rem;

endmodule
`default_nettype wire

// ===== rtl/core/itra_seq.sv =====
`default_nettype none
module itra_seq #(
  parameter int WIDTH = itra_pkg::DEF_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic signed [WIDTH-1:0]      value,
  input  wire logic [itra_pkg::RADIX_W-1:0] radix_eff,
  output      logic                         busy,
  output      logic                         div_go,
  output      logic [WIDTH-1:0]             div_dividend,
  input  wire logic [WIDTH-1:0]             div_quo,
  input  wire itra_pkg::div_res_t           div_res,
  output      logic                         strobe,
  output      logic [7:0]                   char_code,
  output      logic                         last_char,
  output      logic                         was_nonzero
);
  import itra_pkg::*;

  localparam int AW = $clog2(WIDTH);

  seq_state_t state, state_next;

  logic [AW-1:0]      idx, idx_next;
  logic               neg;
  logic               nz;
  logic [WIDTH-1:0]   vin;
  logic               is_zero;
  logic               neg_in;
  logic [WIDTH-1:0]   mag_in;
  logic               accept;
  logic               quo_zero;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [DIGIT_W-1:0] mem_wdata;
  logic [DIGIT_W-1:0] rd_data;
  logic [DIGIT_W-1:0] mem [WIDTH];

  // input decode: zero test, sign only in radix ten
  always_comb begin
    vin     = value;
    is_zero = (vin == '0);
    neg_in  = (radix_eff == RADIX_DEC) && vin[WIDTH-1];
    mag_in  = neg_in ? (~vin + WIDTH'(1)) : vin;
  end

  assign accept   = start && (state == S_IDLE);
  assign quo_zero = (div_quo == '0);
  assign busy     = (state != S_IDLE);

  // divider requests: first digit from the input, then from the quotient
  assign div_go       = (accept && !is_zero) ||
                        ((state == S_DIV) && div_res.done && !quo_zero);
  assign div_dividend = (state == S_IDLE) ? mag_in : div_quo;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = is_zero ? S_SIGN : S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done && quo_zero) begin
          state_next = S_SIGN;
        end
      end
      S_SIGN: state_next = S_EMIT;
      S_EMIT: begin
        if (idx == '0) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // digit index: counts up while dividing, down while emitting
  always_comb begin
    idx_next = idx;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          idx_next = '0;
        end
      end
      S_DIV: begin
        if (div_res.done && !quo_zero) begin
          idx_next = idx + 1'b1;
        end
      end
      S_EMIT:  idx_next = idx - 1'b1;
      default: idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      neg   <= 1'b0;
      nz    <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (accept) begin
        neg <= neg_in;
        nz  <= !is_zero;
      end
    end
  end

  // digit store: remainders least significant first
  always_comb begin
    mem_we    = (accept && is_zero) || ((state == S_DIV) && div_res.done);
    mem_waddr = (state == S_IDLE) ? '0 : idx;
    mem_wdata = (state == S_IDLE) ? '0 : div_res.rem;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[idx_next];
  end

  // result beats
  always_comb begin
    strobe    = 1'b0;
    char_code = CHR_MINUS;
    last_char = 1'b0;
    unique case (state)
      S_SIGN: begin
        strobe = neg;
      end
      S_EMIT: begin
        strobe    = 1'b1;
        char_code = digit_char(rd_data);
        last_char = (idx == '0);
      end
      default: begin
        strobe = 1'b0;
      end
    endcase
  end

  assign was_nonzero = nz;

endmodule
`default_nettype wire

// ===== rtl/core/integer_to_radix_ascii.sv =====
`default_nettype none
// Integer to radix ASCII converter.
// Command channel: value is taken at a clock edge where start is high and
// busy is low; busy then stays high until the last character has gone.
// Config channel: radix is written when cfg_valid and cfg_ready are high;
// cfg_ready is always high. Radix is saturated into 2..36 at use; only
// radix ten prints a leading '-' for negative values.
// Result channel: one ASCII character per beat, most significant first,
// each shown for one cycle with strobe high; last_char marks the final one
// and was_nonzero is clear only for the single '0' of a zero input.
// The receiver cannot stall: beats are not held.
// Sequence: the digits are divided out one after another, since the
// shared restoring divider yields one quotient bit per cycle, then the
// sign state and the characters follow, one per cycle. A zero input
// skips the division. Radix two is the worst case.
// Reset (rst, synchronous) returns to idle and sets radix to ten.
module integer_to_radix_ascii #(
  parameter int WIDTH = itra_pkg::DEF_WIDTH
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [WIDTH-1:0]      value,
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [itra_pkg::RADIX_W-1:0] radix,
  output      logic                         strobe,
  output      logic [7:0]                   char_code,
  output      logic                         last_char,
  output      logic                         was_nonzero
);
  import itra_pkg::*;

  logic [RADIX_W-1:0] radix_cfg;
  logic [RADIX_W-1:0] radix_eff;
  logic               div_go;
  logic [WIDTH-1:0]   div_dividend;
  logic [WIDTH-1:0]   div_quo;
  div_res_t           div_res;

  // radix register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_cfg <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix_cfg <= radix;
    end
  end

  // clamp into the supported range
  always_comb begin
    priority if (radix_cfg < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_cfg > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_cfg;
    end
  end

  itra_seq #(.WIDTH(WIDTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .value        (value),
    .radix_eff    (radix_eff),
    .busy         (busy),
    .div_go       (div_go),
    .div_dividend (div_dividend),
    .div_quo      (div_quo),
    .div_res      (div_res),
    .strobe       (strobe),
    .char_code    (char_code),
    .last_char    (last_char),
    .was_nonzero  (was_nonzero)
  );

  itra_div #(.WIDTH(WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (radix_eff),
    .quo      (div_quo),
    .res      (div_res)
  );

endmodule
`default_nettype wire

// ===== rtl/core/itra_checker.sv =====
`default_nettype none
module itra_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       strobe,
  input wire logic [7:0] char_code,
  input wire logic       last_char,
  input wire logic       was_nonzero
);
  import itra_pkg::*;

  // beats only while a conversion is in progress
  a_beat_in_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("result beat while idle");

  // an accepted command keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accepted command");

  // last character frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_char) |=> !busy)
    else $error("still busy after last character");

  // zero input gives a lone '0'
  a_zero_text: assert property (@(posedge clk) disable iff (rst)
    (strobe && !was_nonzero) |-> (last_char && (char_code == CHR_ZERO)))
    else $error("zero input not a single '0'");

  // a minus sign is never the final character
  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == CHR_MINUS)) |-> (!last_char && was_nonzero))
    else $error("minus sign as last character");

endmodule

bind integer_to_radix_ascii itra_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .strobe      (strobe),
  .char_code   (char_code),
  .last_char   (last_char),
  .was_nonzero (was_nonzero)
);
`default_nettype wire
